[sv/radial_distance_histogram_macros.svh]
// Assertion macros for the radial distance histogram block.
`ifndef RADIAL_DISTANCE_HISTOGRAM_MACROS_SVH
`define RADIAL_DISTANCE_HISTOGRAM_MACROS_SVH
`ifndef SYNTHESIS
`define RDH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rdh assertion failed");
`define RDH_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rdh assertion failed");
`else
`define RDH_ASSERT_IMP(label, ante, cons)
`define RDH_ASSERT_NXT(label, ante, cons)
`endif
`endif

[sv/rdh_pkg.sv]
// Shared types and constants of the radial distance histogram block.
package rdh_pkg;

  localparam int MAX_BEADS = 1024;
  localparam int NUM_BINS  = 2048;
  localparam int BEAD_AW   = $clog2(MAX_BEADS);
  localparam int BCNT_W    = $clog2(MAX_BEADS + 1);
  localparam int HIST_AW   = $clog2(NUM_BINS);
  localparam int CNT_W     = 10;
  localparam logic [CNT_W-1:0] COUNT_MAX = 10'd1023;
  localparam int SHELL_W   = 13;
  localparam int ROOT_IN_W = 26;
  localparam int KIDX_W    = 11;
  localparam int DENS_W    = 24;
  localparam int DIV_STEPS = DENS_W + 1;
  localparam int DEN_W     = 51;
  // 4/3*pi in Q.24
  localparam logic [26:0] FOUR_THIRDS_PI_Q24 = 27'd70276238;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } rdh_pos_t;

  typedef struct packed {
    logic               mode;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic               last_bead;
    logic [10:0]        shell_index;
  } rdh_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [9:0]  shell_count;
    logic [23:0] shell_density;
    logic [9:0]  out_of_range;
    logic [10:0] bead_total;
  } rdh_result_t;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;
  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CTR_RD, S_CTR_LAT, S_SEL, S_BEAD_LAT, S_DIST,
    S_HIST_LAT, S_DONE, S_RD_LAT, S_DENS, S_RESULT
  } rdh_state_t;

  typedef enum logic [1:0] {D_IDLE, D_SQ, D_SUM, D_ROOT} rdh_dist_state_t;

  typedef enum logic [2:0] {V_IDLE, V_SQ, V_M, V_DEN, V_DIV} rdh_div_state_t;

endpackage

[sv/radial_distance_histogram.sv]
// The first bead of a chain adds a clear of all NUM_BINS histogram bins.
// A last bead then walks the bead store, one bead at a time: memory read, squares, sum,
// 13-step square root, and a histogram read-modify-write unless the shell is past the last.
// A shell read runs through the 25-step restoring divider.
// Reset (synchronous, active high) starts a histogram clearing pass;
// no item is taken until it ends. The bead store is not cleared.
module radial_distance_histogram (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  rdh_pkg::rdh_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output rdh_pkg::rdh_result_t result
);

`include "radial_distance_histogram_macros.svh"

  rdh_pkg::rdh_state_t state, state_next;
  logic chain_open, pend_last;
  logic [rdh_pkg::BCNT_W-1:0] bead_count, idx, cnt_eff, cnt_new, center;
  logic [rdh_pkg::CNT_W-1:0] ovf;
  logic [rdh_pkg::HIST_AW-1:0] clr_idx;
  logic store_ok, clr_last, out_free, shell_far;
  logic result_valid_next;

  rdh_pkg::rdh_pos_t bead_mem [rdh_pkg::MAX_BEADS];
  rdh_pkg::rdh_pos_t bead_rdata, center_pos, bead_wdata;
  logic bead_we;
  logic [rdh_pkg::BEAD_AW-1:0] bead_raddr;

  logic [rdh_pkg::CNT_W-1:0] hist_mem [rdh_pkg::NUM_BINS];
  logic [rdh_pkg::CNT_W-1:0] hist_rdata, hist_wdata;
  logic hist_we;
  logic [rdh_pkg::HIST_AW-1:0] hist_raddr, hist_waddr;

  logic dist_start, dist_done;
  logic [rdh_pkg::SHELL_W-1:0] dist_shell;
  logic dens_start, dens_done;
  logic [rdh_pkg::DENS_W-1:0] dens;
  logic [rdh_pkg::KIDX_W-1:0] rd_k;
  logic rd_in_range;
  logic [rdh_pkg::CNT_W-1:0] rd_cnt, rd_cnt_next;
  logic accept;

  rdh_dist u_dist (
    .clk(clk), .rst(rst), .start(dist_start), .center(center_pos), .bead(bead_rdata),
    .done(dist_done), .shell(dist_shell)
  );

  rdh_density u_dens (
    .clk(clk), .rst(rst), .start(dens_start), .k(rd_k), .count(rd_cnt_next),
    .done(dens_done), .density(dens)
  );

  always_comb begin
    accept    = item_valid && item_ready;
    cnt_eff   = chain_open ? bead_count : '0;
    store_ok  = cnt_eff < rdh_pkg::BCNT_W'(rdh_pkg::MAX_BEADS);
    cnt_new   = store_ok ? cnt_eff + 1'b1 : cnt_eff;
    center    = bead_count >> 1;
    clr_last  = clr_idx == rdh_pkg::HIST_AW'(rdh_pkg::NUM_BINS - 1);
    out_free  = !result_valid || result_ready;
    shell_far = 32'(dist_shell) >= rdh_pkg::NUM_BINS;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rdh_pkg::S_CLEAR:
        if (clr_last) state_next = pend_last ? rdh_pkg::S_CTR_RD : rdh_pkg::S_IDLE;
      rdh_pkg::S_IDLE:
        if (item_valid) begin
          priority if (item.mode == rdh_pkg::MODE_READ) state_next = rdh_pkg::S_RD_LAT;
          else if (!chain_open)                         state_next = rdh_pkg::S_CLEAR;
          else if (item.last_bead)                      state_next = rdh_pkg::S_CTR_RD;
          else                                          state_next = rdh_pkg::S_IDLE;
        end
      rdh_pkg::S_CTR_RD:  state_next = rdh_pkg::S_CTR_LAT;
      rdh_pkg::S_CTR_LAT: state_next = rdh_pkg::S_SEL;
      rdh_pkg::S_SEL:
        if (idx == bead_count) state_next = rdh_pkg::S_DONE;
        else if (idx != center) state_next = rdh_pkg::S_BEAD_LAT;
      rdh_pkg::S_BEAD_LAT: state_next = rdh_pkg::S_DIST;
      rdh_pkg::S_DIST:
        if (dist_done) state_next = shell_far ? rdh_pkg::S_SEL : rdh_pkg::S_HIST_LAT;
      rdh_pkg::S_HIST_LAT: state_next = rdh_pkg::S_SEL;
      rdh_pkg::S_RD_LAT:   state_next = rdh_pkg::S_DENS;
      rdh_pkg::S_DENS:     if (dens_done) state_next = rdh_pkg::S_RESULT;
      rdh_pkg::S_DONE, rdh_pkg::S_RESULT:
        if (out_free) state_next = rdh_pkg::S_IDLE;
      default: state_next = rdh_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    item_ready  = (state == rdh_pkg::S_IDLE);
    bead_we     = item_ready && item_valid && item.mode == rdh_pkg::MODE_LOAD && store_ok;
    bead_wdata  = '{x: item.pos_x, y: item.pos_y, z: item.pos_z};
    bead_raddr  = (state == rdh_pkg::S_CTR_RD) ? center[rdh_pkg::BEAD_AW-1:0]
                                               : idx[rdh_pkg::BEAD_AW-1:0];
    hist_raddr  = (state == rdh_pkg::S_IDLE) ? item.shell_index[rdh_pkg::HIST_AW-1:0]
                                             : dist_shell[rdh_pkg::HIST_AW-1:0];
    hist_we     = (state == rdh_pkg::S_CLEAR) || (state == rdh_pkg::S_HIST_LAT);
    hist_waddr  = (state == rdh_pkg::S_CLEAR) ? clr_idx : dist_shell[rdh_pkg::HIST_AW-1:0];
    if (state == rdh_pkg::S_CLEAR)        hist_wdata = '0;
    else if (hist_rdata == rdh_pkg::COUNT_MAX) hist_wdata = hist_rdata;
    else                                   hist_wdata = hist_rdata + 1'b1;
    dist_start  = (state == rdh_pkg::S_BEAD_LAT);
    dens_start  = (state == rdh_pkg::S_RD_LAT);
    rd_cnt_next = rd_in_range ? hist_rdata : '0;
    // a new beat may be loaded as the waiting one leaves
    result_valid_next = (((state == rdh_pkg::S_DONE) || (state == rdh_pkg::S_RESULT))
                         && out_free) || (result_valid && !result_ready);
  end

  always_ff @(posedge clk) begin
    if (bead_we) bead_mem[cnt_eff[rdh_pkg::BEAD_AW-1:0]] <= bead_wdata;
    bead_rdata <= bead_mem[bead_raddr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_rdata <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rdh_pkg::S_CLEAR;
      chain_open   <= 1'b0;
      pend_last    <= 1'b0;
      bead_count   <= '0;
      ovf          <= '0;
      clr_idx      <= '0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
      unique case (state)
        rdh_pkg::S_CLEAR: clr_idx <= clr_idx + 1'b1;
        rdh_pkg::S_IDLE:
          if (accept && item.mode == rdh_pkg::MODE_LOAD) begin
            bead_count <= cnt_new;
            idx        <= '0;
            if (!chain_open) begin
              chain_open <= 1'b1;
              ovf        <= '0;
              clr_idx    <= '0;
              pend_last  <= item.last_bead;
            end
          end
        rdh_pkg::S_SEL:
          if (idx != bead_count && idx == center) idx <= idx + 1'b1;
        rdh_pkg::S_DIST:
          if (dist_done && shell_far) begin
            if (ovf != rdh_pkg::COUNT_MAX) ovf <= ovf + 1'b1;
            idx <= idx + 1'b1;
          end
        rdh_pkg::S_HIST_LAT: idx <= idx + 1'b1;
        rdh_pkg::S_DONE:
          if (out_free) begin
            chain_open   <= 1'b0;
            pend_last    <= 1'b0;
          end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == rdh_pkg::S_CTR_LAT) center_pos <= bead_rdata;
    if (accept && item.mode == rdh_pkg::MODE_READ) begin
      rd_k        <= item.shell_index;
      rd_in_range <= 32'(item.shell_index) < rdh_pkg::NUM_BINS;
    end
    if (state == rdh_pkg::S_RD_LAT) rd_cnt <= rd_cnt_next;
    if (state == rdh_pkg::S_DONE && out_free) begin
      result <= '{result_kind: rdh_pkg::KIND_DONE, shell_count: '0, shell_density: '0,
                  out_of_range: ovf, bead_total: bead_count};
    end
    if (state == rdh_pkg::S_RESULT && out_free) begin
      result <= '{result_kind: rdh_pkg::KIND_READ, shell_count: rd_cnt,
                  shell_density: dens, out_of_range: '0, bead_total: '0};
    end
  end

  `RDH_ASSERT_IMP(a_clear_writes_zero, state == rdh_pkg::S_CLEAR, hist_we && hist_wdata == '0)
  `RDH_ASSERT_NXT(a_read_goes_to_hist, accept && item.mode == rdh_pkg::MODE_READ, state == rdh_pkg::S_RD_LAT)
  `RDH_ASSERT_IMP(a_count_bound, 1'b1, bead_count <= rdh_pkg::BCNT_W'(rdh_pkg::MAX_BEADS))
  `RDH_ASSERT_IMP(a_walk_bound, state == rdh_pkg::S_SEL, idx <= bead_count)

endmodule

[sv/rdh_dist.sv]
// Squared distance and iterative integer square root giving the shell index.
module rdh_dist (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rdh_pkg::rdh_pos_t center,
  input  rdh_pkg::rdh_pos_t bead,
  output logic              done,
  output logic [rdh_pkg::SHELL_W-1:0] shell
);

  rdh_pkg::rdh_dist_state_t state, state_next;
  logic signed [24:0] dx, dy, dz;
  logic [48:0] sqx, sqy, sqz;
  logic [rdh_pkg::ROOT_IN_W-1:0] v;
  logic [rdh_pkg::SHELL_W-1:0] mask;
  logic [rdh_pkg::SHELL_W-1:0] trial;
  logic [2*rdh_pkg::SHELL_W-1:0] trial_sq;
  logic [50:0] sum;
  logic root_step;

  always_comb begin
    state_next = state;
    unique case (state)
      rdh_pkg::D_IDLE: if (start) state_next = rdh_pkg::D_SQ;
      rdh_pkg::D_SQ:   state_next = rdh_pkg::D_SUM;
      rdh_pkg::D_SUM:  state_next = rdh_pkg::D_ROOT;
      rdh_pkg::D_ROOT: if (mask[0]) state_next = rdh_pkg::D_IDLE;
      default:         state_next = rdh_pkg::D_IDLE;
    endcase
  end

  always_comb begin
    root_step = (state == rdh_pkg::D_ROOT);
    trial     = shell | mask;
    trial_sq  = trial * trial;
    sum       = 51'(sqx) + 51'(sqy) + 51'(sqz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdh_pkg::D_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= root_step && mask[0];
    end
  end

  always_ff @(posedge clk) begin
    if (start && state == rdh_pkg::D_IDLE) begin
      dx <= 25'(bead.x) - 25'(center.x);
      dy <= 25'(bead.y) - 25'(center.y);
      dz <= 25'(bead.z) - 25'(center.z);
    end
    if (state == rdh_pkg::D_SQ) begin
      sqx <= 49'(dx * dx);
      sqy <= 49'(dy * dy);
      sqz <= 49'(dz * dz);
    end
    if (state == rdh_pkg::D_SUM) begin
      v     <= sum[24 +: rdh_pkg::ROOT_IN_W];
      shell <= '0;
      mask  <= {1'b1, {(rdh_pkg::SHELL_W-1){1'b0}}};
    end
    if (root_step) begin
      // one result bit per cycle, most significant first
      if (trial_sq <= v) shell <= trial;
      mask <= mask >> 1;
    end
  end

endmodule

[sv/rdh_density.sv]
// Shell density: count * 2^16 / (4/3*pi * (3k^2+3k+1)) by restoring division.
module rdh_density (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rdh_pkg::KIDX_W-1:0]    k,
  input  logic [rdh_pkg::CNT_W-1:0]     count,
  output logic                          done,
  output logic [rdh_pkg::DENS_W-1:0]    density
);

  rdh_pkg::rdh_div_state_t state, state_next;
  logic [rdh_pkg::KIDX_W-1:0] k_q;
  logic [rdh_pkg::CNT_W-1:0]  cnt_q;
  logic [2*rdh_pkg::KIDX_W-1:0] ksq;
  logic [23:0] m;
  logic [49:0] rem;
  logic [rdh_pkg::DEN_W+rdh_pkg::DENS_W-1:0] dsh;
  logic [rdh_pkg::DENS_W:0] q;
  logic [4:0] step;
  logic last_step, fits;

  function automatic logic [rdh_pkg::DEN_W-1:0] FOUR_THIRDS_PI_Q24_m(input logic [23:0] mv);
    FOUR_THIRDS_PI_Q24_m = rdh_pkg::DEN_W'(rdh_pkg::FOUR_THIRDS_PI_Q24 * mv);
  endfunction

  always_comb begin
    state_next = state;
    unique case (state)
      rdh_pkg::V_IDLE: if (start) state_next = rdh_pkg::V_SQ;
      rdh_pkg::V_SQ:   state_next = rdh_pkg::V_M;
      rdh_pkg::V_M:    state_next = rdh_pkg::V_DEN;
      rdh_pkg::V_DEN:  state_next = rdh_pkg::V_DIV;
      rdh_pkg::V_DIV:  if (last_step) state_next = rdh_pkg::V_IDLE;
      default:         state_next = rdh_pkg::V_IDLE;
    endcase
  end

  always_comb begin
    last_step = (state == rdh_pkg::V_DIV) && (step == 5'(rdh_pkg::DIV_STEPS - 1));
    fits      = (75'(rem) >= dsh);
    density   = q[rdh_pkg::DENS_W] ? {rdh_pkg::DENS_W{1'b1}} : q[rdh_pkg::DENS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdh_pkg::V_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= last_step;
    end
  end

  always_ff @(posedge clk) begin
    if (start && state == rdh_pkg::V_IDLE) begin
      k_q   <= k;
      cnt_q <= count;
    end
    if (state == rdh_pkg::V_SQ) ksq <= k_q * k_q;
    if (state == rdh_pkg::V_M) m <= 24'(3 * 24'(ksq)) + 24'(3 * 24'(k_q)) + 24'd1;
    if (state == rdh_pkg::V_DEN) begin
      dsh  <= {51'(FOUR_THIRDS_PI_Q24_m(m)), {rdh_pkg::DENS_W{1'b0}}};
      rem  <= {cnt_q, 40'b0};
      q    <= '0;
      step <= '0;
    end
    if (state == rdh_pkg::V_DIV) begin
      if (fits) begin
        rem <= rem - dsh[49:0];
        q   <= {q[rdh_pkg::DENS_W-1:0], 1'b1};
      end else begin
        q   <= {q[rdh_pkg::DENS_W-1:0], 1'b0};
      end
      dsh  <= dsh >> 1;
      step <= step + 5'd1;
    end
  end

endmodule

[tb/radial_distance_histogram_tb.sv]
// Self-checking bench for the radial distance histogram: random chains and shell reads.
`timescale 1ns / 1ps

module radial_distance_histogram_tb;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int HOLD_CYCLES    = 2000;
  localparam int Q12            = 4096;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  rdh_pkg::rdh_item_t   item = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  rdh_pkg::rdh_result_t result;

  radial_distance_histogram DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the block's state
  logic signed [23:0] bead_pos [0:rdh_pkg::MAX_BEADS-1][0:2];
  int unsigned        beads_held;
  logic [9:0]         shell_hist [0:rdh_pkg::NUM_BINS-1];
  logic [9:0]         far_beads;
  bit                 chain_open;

  rdh_pkg::rdh_item_t   pending_items[$];
  rdh_pkg::rdh_result_t expected_results[$];

  int unsigned beats_in, beats_out, chains_closed, reads_checked, mismatches;
  int unsigned idle_cycles;
  bit          hold_done;
  int unsigned hold_left;
  bit          calm;

  assign calm = (beats_in >= 400) && (beats_in < 700);

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // walks the closed chain against its middle bead
  task automatic bin_chain();
    int unsigned     centre;
    longint          dx, dy, dz;
    longint unsigned d2, shell;
    centre = beads_held / 2;
    for (int unsigned i = 0; i < beads_held; i++) begin
      if (i != centre) begin
        dx = longint'(bead_pos[i][0]) - longint'(bead_pos[centre][0]);
        dy = longint'(bead_pos[i][1]) - longint'(bead_pos[centre][1]);
        dz = longint'(bead_pos[i][2]) - longint'(bead_pos[centre][2]);
        d2 = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
        shell = int_sqrt(d2 >> 24);
        if (shell >= rdh_pkg::NUM_BINS) begin
          if (far_beads != rdh_pkg::COUNT_MAX) far_beads++;
        end else if (shell_hist[shell] != rdh_pkg::COUNT_MAX) begin
          shell_hist[shell]++;
        end
      end
    end
  endtask

  task automatic predict_histogram(input rdh_pkg::rdh_item_t it);
    rdh_pkg::rdh_result_t r;
    longint unsigned      vol, dens;
    r = '0;
    if (it.mode == rdh_pkg::MODE_READ) begin
      r.result_kind = rdh_pkg::KIND_READ;
      if (it.shell_index < rdh_pkg::NUM_BINS) begin
        vol  = 3 * longint'(it.shell_index) * it.shell_index + 3 * it.shell_index + 1;
        dens = (longint'(shell_hist[it.shell_index]) << 40)
               / (rdh_pkg::FOUR_THIRDS_PI_Q24 * vol);
        r.shell_count   = shell_hist[it.shell_index];
        r.shell_density = (dens > 64'hFFFFFF) ? 24'hFFFFFF : dens[23:0];
      end
      expected_results.push_back(r);
      return;
    end
    if (!chain_open) begin
      foreach (shell_hist[k]) shell_hist[k] = '0;
      far_beads  = '0;
      beads_held = 0;
      chain_open = 1'b1;
    end
    if (beads_held < rdh_pkg::MAX_BEADS) begin
      bead_pos[beads_held][0] = it.pos_x;
      bead_pos[beads_held][1] = it.pos_y;
      bead_pos[beads_held][2] = it.pos_z;
      beads_held++;
    end
    if (!it.last_bead) return;
    bin_chain();
    chain_open = 1'b0;
    r.result_kind  = rdh_pkg::KIND_DONE;
    r.out_of_range = far_beads;
    r.bead_total   = beads_held[10:0];
    expected_results.push_back(r);
  endtask

  task automatic add_bead(input int x, input int y, input int z, input bit last);
    rdh_pkg::rdh_item_t it;
    logic [95:0]        noise;
    noise = {$urandom, $urandom, $urandom};
    it = noise[$bits(rdh_pkg::rdh_item_t)-1:0];
    it.mode      = rdh_pkg::MODE_LOAD;
    it.pos_x     = x[23:0];
    it.pos_y     = y[23:0];
    it.pos_z     = z[23:0];
    it.last_bead = last;
    pending_items.push_back(it);
  endtask

  task automatic add_read(input int k);
    rdh_pkg::rdh_item_t it;
    logic [95:0]        noise;
    noise = {$urandom, $urandom, $urandom};
    it = noise[$bits(rdh_pkg::rdh_item_t)-1:0];
    it.mode        = rdh_pkg::MODE_READ;
    it.shell_index = k[10:0];
    pending_items.push_back(it);
  endtask

  function automatic int near_coord(input int base);
    return base + $urandom_range(40 * Q12) - 20 * Q12;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        predict_histogram(item);
        beats_in++;
      end
      if (item_valid && !item_ready) begin
        // hold the beat
      end else if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
        item       <= pending_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off once reads have started flowing
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      result_ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && reads_checked >= 100) begin
      result_ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      result_ready <= calm || ($urandom_range(99) >= 33);
    end
  end

  // monitor
  always @(posedge clk) begin
    rdh_pkg::rdh_result_t want;
    if (!rst && result_valid && result_ready) begin
      beats_out++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", result);
      end else begin
        want = expected_results.pop_front();
        if (want.result_kind == rdh_pkg::KIND_READ) reads_checked++;
        else chains_closed++;
        if (result !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, result);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("** radial_distance_histogram: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n, bx, by, bz;
    beats_in = 0; beats_out = 0; chains_closed = 0; reads_checked = 0; mismatches = 0;
    beads_held = 0; far_beads = '0; chain_open = 1'b0;
    foreach (shell_hist[k]) shell_hist[k] = '0;

    // directed: empty read, lone bead, extreme corners, small chain with reads mid-chain
    add_read(0);
    add_bead(0, 0, 0, 1'b1);
    add_bead(-8388608, -8388608, -8388608, 1'b0);
    add_bead(8388607, 8388607, 8388607, 1'b1);
    add_read(0);
    add_bead(0, 0, 0, 1'b0);
    add_read(0);
    add_bead(Q12, 0, 0, 1'b0);
    add_bead(0, 5 * Q12 / 2, 0, 1'b1);
    add_read(1);
    add_read(2);
    add_read(rdh_pkg::NUM_BINS - 1);
    // store overrun: even beads sit on the centre, odd ones beyond the last shell
    for (int i = 0; i < rdh_pkg::MAX_BEADS + 6; i++)
      if (i % 2 == 1) add_bead(8388607, 8388607, 8388607, i == rdh_pkg::MAX_BEADS + 5);
      else add_bead(7, -3, 11, i == rdh_pkg::MAX_BEADS + 5);
    add_read(0);

    // random chains with reads interleaved
    while (pending_items.size() < 1300) begin
      n  = ($urandom_range(19) == 0) ? $urandom_range(200, 30) : $urandom_range(12, 1);
      bx = $urandom_range(400 * Q12) - 200 * Q12;
      by = $urandom_range(400 * Q12) - 200 * Q12;
      bz = $urandom_range(400 * Q12) - 200 * Q12;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0)
          add_bead($urandom, $urandom, $urandom, i == n - 1);
        else
          add_bead(near_coord(bx), near_coord(by), near_coord(bz), i == n - 1);
        if ($urandom_range(4) == 0)
          add_read(($urandom_range(3) == 0) ? $urandom_range(rdh_pkg::NUM_BINS - 1)
                                            : $urandom_range(40));
      end
      for (int i = $urandom_range(3); i > 0; i--)
        add_read(($urandom_range(3) == 0) ? $urandom_range(rdh_pkg::NUM_BINS - 1)
                                          : $urandom_range(40));
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d input beats, %0d chains closed, %0d shell reads checked",
             beats_in, chains_closed, reads_checked);
    $display("covered store overrun, far shells, lone beads and reads mid-chain");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("** radial_distance_histogram: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** radial_distance_histogram: FAILED **");
    end
    $finish;
  end

endmodule
